### src/ps2mi_pkg.sv
// ----------------------------------------------------------------------------
// ps2mi_pkg
// Types, constants and the script ROM of the PS/2 mouse init sequencer.
// ----------------------------------------------------------------------------
package ps2mi_pkg;

   localparam int SCRIPT_LEN_DEF = 16;
   localparam int ROM_SLOTS      = 64;
   localparam int ROM_IDX_W      = 6;

   localparam logic [7:0] TIMEOUT_RESET = 8'd175;  // 3500 ms at a 20 ms poll
   localparam logic [6:0] COUNT_ONE     = 7'd1;

   localparam logic OP_POLL    = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   typedef struct packed {
      logic       op;
      logic       rx_valid;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       rx_taken;
      logic       timed_out;
      logic       finished;
   } rsp_type;

   typedef struct packed {
      logic [6:0] send_left;
      logic [6:0] recv_left;
      logic [7:0] wait_ticks;
   } ctr_type;

   // Script: reset, wait for two reply bytes, set sample rates and read ID,
   // then enable streaming.
   function automatic logic [7:0] rom_byte(input logic [ROM_IDX_W-1:0] idx);
      logic [7:0] b;
      case (idx)
         6'd0:    b = 8'h01;
         6'd1:    b = 8'hff;
         6'd2:    b = 8'h82;
         6'd3:    b = 8'h08;
         6'd4:    b = 8'hf3;
         6'd5:    b = 8'hc8;
         6'd6:    b = 8'hf3;
         6'd7:    b = 8'h64;
         6'd8:    b = 8'hf3;
         6'd9:    b = 8'h50;
         6'd10:   b = 8'hf2;
         6'd11:   b = 8'h01;
         6'd12:   b = 8'h81;
         6'd13:   b = 8'h01;
         6'd14:   b = 8'hf4;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

### src/ps2mi_step.sv
// ----------------------------------------------------------------------------
// ps2mi_step
// Next-state and result logic for one poll slot of the script sequencer.
// ----------------------------------------------------------------------------
module ps2mi_step
   import ps2mi_pkg::*;
#(
   parameter int SCRIPT_LEN = SCRIPT_LEN_DEF,
   localparam int POS_W     = $clog2(SCRIPT_LEN + 1)
) (
   input  req_type          req,
   input  logic [7:0]       timeout_ticks,
   input  logic [POS_W-1:0] pos_cur,
   input  ctr_type          ctr_cur,
   output logic [POS_W-1:0] pos_nxt,
   output ctr_type          ctr_nxt,
   output rsp_type          rsp
);

   localparam logic [POS_W-1:0] LEN_P = POS_W'(SCRIPT_LEN);

   logic [POS_W-1:0] pos;
   logic [POS_W-1:0] pos_adv;
   logic [7:0]       rom_b;
   logic [7:0]       wt;
   logic [6:0]       dec_send;
   logic [6:0]       dec_recv;
   logic [6:0]       recv_t;

   always_comb begin
      wt       = (ctr_cur.wait_ticks != 8'd0) ? ctr_cur.wait_ticks - 8'd1 : 8'd0;
      pos      = (req.op == OP_RESTART) ? '0 : pos_cur;
      // past the end the script reads as zero, which ends it
      rom_b    = (pos < LEN_P) ? rom_byte(ROM_IDX_W'(pos)) : 8'h00;
      pos_adv  = (pos < LEN_P) ? pos + POS_W'(1) : pos;
      dec_send = rom_b[7] ? 7'd0 : rom_b[6:0];
      dec_recv = rom_b[7] ? rom_b[6:0] : 7'd0;
      recv_t   = ctr_cur.recv_left;

      pos_nxt            = pos;
      ctr_nxt            = ctr_cur;
      ctr_nxt.wait_ticks = wt;
      rsp                = '0;

      if (pos == '0) begin
         // drop whatever arrives at the script start
         rsp.rx_taken      = req.rx_valid;
         pos_nxt           = pos_adv;
         ctr_nxt.send_left = dec_send;
         ctr_nxt.recv_left = dec_recv;
      end else if (ctr_cur.recv_left != 7'd0) begin
         if (req.rx_valid) begin
            rsp.rx_taken = 1'b1;
            recv_t       = ctr_cur.recv_left - COUNT_ONE;
         end else if (wt == 8'd0) begin
            rsp.timed_out = 1'b1;
            pos_nxt       = '0;
         end
         if (pos_nxt != '0 && ctr_cur.send_left == 7'd0 && recv_t == 7'd0) begin
            pos_nxt           = pos_adv;
            ctr_nxt.send_left = dec_send;
            ctr_nxt.recv_left = dec_recv;
         end else begin
            ctr_nxt.recv_left = recv_t;
         end
      end else if (ctr_cur.send_left != 7'd0) begin
         rsp.tx_valid       = 1'b1;
         rsp.tx_byte        = rom_b;
         pos_nxt            = pos_adv;
         ctr_nxt.send_left  = ctr_cur.send_left - COUNT_ONE;
         ctr_nxt.recv_left  = COUNT_ONE;
         ctr_nxt.wait_ticks = timeout_ticks;
      end

      rsp.finished = (pos_nxt != '0) && (ctr_nxt.send_left == 7'd0)
                     && (ctr_nxt.recv_left == 7'd0);
   end

endmodule

### src/ps2_mouse_init_script_sequencer_top.sv
// ----------------------------------------------------------------------------
// ps2_mouse_init_script_sequencer_top
// PS/2 mouse init script sequencer: input register, step logic, result register.
// ----------------------------------------------------------------------------
// Path: a request is captured in the input register and its result in the result register; a blocked result holds both.
// Throughput: one item per cycle while results are taken; the script state updates as each item
// leaves the input register, so the next item sees it at once.
// Reset: script position, counters and both stages clear; the timeout
// register loads 175. The script ROM is a constant table.
module ps2_mouse_init_script_sequencer_top
   import ps2mi_pkg::*;
#(
   parameter int SCRIPT_LEN = SCRIPT_LEN_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_op,
   input  logic       req_rx_valid,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_tx_valid,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_rx_taken,
   output logic       rsp_timed_out,
   output logic       rsp_finished
);

   localparam int POS_W = $clog2(SCRIPT_LEN + 1);

   logic [7:0]       timeout_ff;
   logic             s1_valid_ff;
   req_type          s1_req_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;
   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   ctr_type          ctr_ff;
   ctr_type          ctr_in;
   rsp_type          rsp_in;
   logic             step_fire;

   assign step_fire = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || step_fire;

   ps2mi_step #(
      .SCRIPT_LEN (SCRIPT_LEN)
   ) u_step (
      .req           (s1_req_ff),
      .timeout_ticks (timeout_ff),
      .pos_cur       (pos_ff),
      .ctr_cur       (ctr_ff),
      .pos_nxt       (pos_in),
      .ctr_nxt       (ctr_in),
      .rsp           (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TIMEOUT_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         ctr_ff       <= '0;
      end else begin
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (step_fire) begin
            rsp_valid_ff <= 1'b1;
            pos_ff       <= pos_in;
            ctr_ff       <= ctr_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_req_ff <= '{op: req_op, rx_valid: req_rx_valid, rx_byte: req_rx_byte};
      end
      if (step_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_tx_valid  = rsp_ff.tx_valid;
   assign rsp_tx_byte   = rsp_ff.tx_byte;
   assign rsp_rx_taken  = rsp_ff.rx_taken;
   assign rsp_timed_out = rsp_ff.timed_out;
   assign rsp_finished  = rsp_ff.finished;

   // a send arms exactly one acknowledge wait with the full timeout
   a_send_arms_wait: assert property (@(posedge clock) disable iff (reset)
      step_fire && rsp_in.tx_valid |=>
         ctr_ff.recv_left == COUNT_ONE && ctr_ff.wait_ticks == $past(timeout_ff))
      else $error("send did not arm the reply wait");

   a_timeout_restarts: assert property (@(posedge clock) disable iff (reset)
      step_fire && rsp_in.timed_out |=> pos_ff == '0)
      else $error("timeout did not return to script start");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(SCRIPT_LEN))
      else $error("script position beyond script length");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid_ff && rsp_valid_ff && !rsp_ready)
      else $error("input stalled without a blocked result");

   a_tx_excludes_rx: assert property (@(posedge clock) disable iff (reset)
      step_fire && rsp_in.tx_valid |-> !rsp_in.rx_taken && !rsp_in.timed_out)
      else $error("send slot also took a byte or timed out");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the PS/2 mouse init script sequencer. A tracker
// steps its own copy of the script state for every accepted poll slot and
// compares each returned result field by field. The stimulus walks the whole
// script with replies first. Random phases follow, each under its own reply
// timeout. They mix answered slots, silences that can force timeouts,
// restarts and floods of offered bytes. Both channels idle and stall at
// random.
// ----------------------------------------------------------------------------
module testbench;
   import ps2mi_pkg::*;

   localparam int SCRIPT_LEN       = 16;
   localparam int QUIET_LIMIT      = 2000;
   localparam int RANDOM_PER_PHASE = 250;

   localparam logic [7:0] INIT_SCRIPT [SCRIPT_LEN] = '{
      8'h01, 8'hff, 8'h82, 8'h08, 8'hf3, 8'hc8, 8'hf3, 8'h64,
      8'hf3, 8'h50, 8'hf2, 8'h01, 8'h81, 8'h01, 8'hf4, 8'h00
   };
   localparam logic [7:0] RX_PATTERNS [4] = '{8'h00, 8'hff, 8'h55, 8'haa};

   class script_slot_tracker;
      logic [7:0] timeout_ticks;
      logic [6:0] script_pos;
      logic [6:0] send_left;
      logic [6:0] recv_left;
      logic [7:0] wait_ticks;
      rsp_type    awaited_results[$];
      int         mismatches;

      function new();
         timeout_ticks = TIMEOUT_RESET;
         script_pos    = '0;
         send_left     = '0;
         recv_left     = '0;
         wait_ticks    = '0;
         mismatches    = 0;
      endfunction

      function void set_timeout(logic [7:0] ticks);
         timeout_ticks = ticks;
      endfunction

      // Past the end of the script every byte reads as zero.
      function logic [7:0] take_script_byte();
         logic [7:0] b;
         b = 8'h00;
         if (script_pos < SCRIPT_LEN) begin
            b = INIT_SCRIPT[script_pos];
            script_pos = script_pos + 7'd1;
         end
         return b;
      endfunction

      function void load_count();
         logic [7:0] b;
         b = take_script_byte();
         if (b[7]) begin
            recv_left = b[6:0];
            send_left = '0;
         end else begin
            send_left = b[6:0];
            recv_left = '0;
         end
      endfunction

      function rsp_type advance_slot(req_type item);
         rsp_type res;
         res = '0;
         if (wait_ticks != 0)
            wait_ticks = wait_ticks - 8'd1;
         if (item.op == OP_RESTART)
            script_pos = '0;

         if (script_pos == 0) begin
            // drop whatever is offered at script start
            res.rx_taken = item.rx_valid;
            load_count();
         end else if (recv_left != 0) begin
            if (item.rx_valid) begin
               res.rx_taken = 1'b1;
               recv_left = recv_left - 7'd1;
            end else if (wait_ticks == 0) begin
               res.timed_out = 1'b1;
               script_pos = '0;
            end
            if (script_pos != 0 && send_left == 0 && recv_left == 0)
               load_count();
         end else if (send_left != 0) begin
            res.tx_valid = 1'b1;
            res.tx_byte  = take_script_byte();
            send_left    = send_left - 7'd1;
            recv_left    = 7'd1;
            wait_ticks   = timeout_ticks;
         end

         res.finished = (script_pos != 0 && send_left == 0 && recv_left == 0);
         return res;
      endfunction

      function void note_request(req_type item);
         awaited_results.push_back(advance_slot(item));
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (awaited_results.size() == 0) begin
            $error("result transfer with no slot outstanding");
            mismatches++;
            return;
         end
         want = awaited_results.pop_front();
         compare_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
         compare_field("tx_byte", want.tx_byte, got.tx_byte);
         compare_field("rx_taken", 8'(want.rx_taken), 8'(got.rx_taken));
         compare_field("timed_out", 8'(want.timed_out), 8'(got.timed_out));
         compare_field("finished", 8'(want.finished), 8'(got.finished));
      endfunction

      function int pending();
         return awaited_results.size();
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;
   logic       req_valid;
   logic       req_ready;
   logic       req_op;
   logic       req_rx_valid;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_tx_valid;
   logic [7:0] rsp_tx_byte;
   logic       rsp_rx_taken;
   logic       rsp_timed_out;
   logic       rsp_finished;

   script_slot_tracker tracker;
   bit sender_steady = 1'b0;
   int quiet_cycles  = 0;

   ps2_mouse_init_script_sequencer_top #(
      .SCRIPT_LEN(SCRIPT_LEN)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_rx_valid (req_rx_valid),
      .req_rx_byte  (req_rx_byte),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_tx_valid (rsp_tx_valid),
      .rsp_tx_byte  (rsp_tx_byte),
      .rsp_rx_taken (rsp_rx_taken),
      .rsp_timed_out(rsp_timed_out),
      .rsp_finished (rsp_finished)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap(bit steady);
      int r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 45)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Returns at the clock edge of the transfer.
   task automatic drive_slot(input logic op, input logic rxv, input logic [7:0] rb);
      req_type item;
      int      gap;
      item.op       = op;
      item.rx_valid = rxv;
      item.rx_byte  = rb;
      gap = pick_gap(sender_steady);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_rx_valid <= rxv;
      req_rx_byte  <= rb;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      tracker.note_request(item);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [7:0] ticks);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= ticks;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tracker.set_timeout(ticks);
   endtask

   task automatic run_random_phase(input int budget, input logic [7:0] ticks);
      int   sent;
      int   len;
      int   kind;
      int   k;
      logic op;
      logic rxv;
      sent = 0;
      while (sent < budget) begin
         kind = $urandom_range(0, 99);
         sender_steady = ($urandom_range(0, 5) == 0);
         if (kind < 75)
            len = $urandom_range(1, 24);
         else if (kind < 85)
            len = $urandom_range(1, int'(ticks) + 3);
         else
            len = $urandom_range(1, 12);
         for (k = 0; k < len; k++) begin
            if (kind < 75) begin
               // answered traffic with an occasional restart
               op  = ($urandom_range(0, 99) < 3) ? OP_RESTART : OP_POLL;
               rxv = ($urandom_range(0, 99) < 65);
            end else if (kind < 85) begin
               // silence that can run long enough to run out the reply wait
               op  = OP_POLL;
               rxv = 1'b0;
            end else if (kind < 93) begin
               op  = ($urandom_range(0, 3) == 0) ? OP_RESTART : OP_POLL;
               rxv = 1'b1;
            end else begin
               op  = $urandom_range(0, 1) ? OP_RESTART : OP_POLL;
               rxv = 1'($urandom_range(0, 1));
            end
            drive_slot(op, rxv, 8'($urandom_range(0, 255)));
         end
         sent += len;
      end
      sender_steady = 1'b0;
   endtask

   initial begin
      int run;
      int stall;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         run = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 8);
         rsp_ready <= 1'b1;
         repeat (run) @(posedge clock);
         stall = pick_gap(1'b0);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // Sample at the falling edge, where both sides are settled.
   always @(negedge clock) begin
      rsp_type got;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.tx_valid  = rsp_tx_valid;
            got.tx_byte   = rsp_tx_byte;
            got.rx_taken  = rsp_rx_taken;
            got.timed_out = rsp_timed_out;
            got.finished  = rsp_finished;
            tracker.check_response(got);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int i;
      tracker = new();
      reset        <= 1'b1;
      csr_wr_en    <= 1'b0;
      csr_wr_data  <= 8'h00;
      req_valid    <= 1'b0;
      req_op       <= OP_POLL;
      req_rx_valid <= 1'b0;
      req_rx_byte  <= 8'h00;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Walk the whole script with a byte offered on each of its slots: dropped at
      // the start, ignored while sending, taken as acks and replies.
      drive_slot(OP_RESTART, 1'b1, 8'hff);
      for (i = 0; i < 23; i++)
         drive_slot(OP_POLL, 1'b1, RX_PATTERNS[i % 4]);
      drive_slot(OP_POLL, 1'b1, 8'h00);
      drive_slot(OP_POLL, 1'b0, 8'h00);
      drive_slot(OP_RESTART, 1'b0, 8'h80);

      write_timeout(8'd1);
      run_random_phase(RANDOM_PER_PHASE, 8'd1);
      write_timeout(8'd255);
      run_random_phase(RANDOM_PER_PHASE, 8'd255);
      write_timeout(8'd0);
      run_random_phase(RANDOM_PER_PHASE, 8'd0);
      write_timeout(8'd2);
      run_random_phase(RANDOM_PER_PHASE, 8'd2);
      for (i = 0; i < 3; i++) begin
         write_timeout(8'($urandom_range(1, 255)));
         run_random_phase(RANDOM_PER_PHASE, tracker.timeout_ticks);
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
